// ===== rtl/jfhs_pkg.sv =====
// Shared types and constants for the JPEG frame header scanner.
`default_nettype none

package jfhs_pkg;

	typedef enum logic [2:0] {
		STATUS_OK       = 3'd0,
		STATUS_NO_SOI   = 3'd1,
		STATUS_LOST     = 3'd2,
		STATUS_BAD_COMP = 3'd3,
		STATUS_TRUNC    = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		COLOR_GRAY = 2'd0,
		COLOR_RGB  = 2'd1,
		COLOR_CMYK = 2'd2
	} color_space_t;

	localparam logic [15:0] MARKER_SOI  = 16'hFFD8;
	localparam logic [15:0] MARKER_SOF0 = 16'hFFC0;
	localparam logic [15:0] MARKER_SOF1 = 16'hFFC1;
	localparam logic [15:0] MARKER_SOF2 = 16'hFFC2;
	localparam logic [15:0] MARKER_SOF9 = 16'hFFC9;
	localparam logic [7:0]  MARKER_PREFIX = 8'hFF;

	localparam logic [7:0] COMPONENTS_GRAY = 8'd1;
	localparam logic [7:0] COMPONENTS_RGB  = 8'd3;
	localparam logic [7:0] COMPONENTS_CMYK = 8'd4;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} feed_payload_t;

	typedef struct packed {
		status_t      status;
		logic [15:0]  height;
		logic [15:0]  width;
		logic [7:0]   precision;
		color_space_t color_space;
		logic         invert_decode;
	} result_payload_t;

endpackage

`default_nettype wire

// ===== rtl/jfhs_stream_if.sv =====
// Valid/ready stream channel carrying one payload per transaction.
`default_nettype none

interface jfhs_stream_if #(
	parameter type payload_t = logic
) ();
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== rtl/jpeg_frame_header_scanner_top.sv =====
// Top level of the JPEG frame header scanner: byte-wise marker walk and SOF capture.
//
// The feed channel takes one file byte per transaction, with last_byte set on the
// final byte of a file. The result channel gives at most one transaction per file:
// the frame size, precision and color space from the first SOF0, SOF1, SOF2 or SOF9
// segment, or an error status with all other fields zero.
// Each byte is handled in the cycle it is accepted, so a result appears on the
// result channel in the cycle after the byte that completes it. One byte is taken
// every cycle; the only limit is the single result register, which frees itself
// in the same cycle its transaction completes.
// After a result the remaining bytes of the file are consumed and dropped; the
// byte marked last returns the scanner to its start state for the next file.
// When the receiver stalls with a result waiting, feed.ready drops until that
// result is taken. Reset clears the parse state and empties the result register.
`default_nettype none

module jpeg_frame_header_scanner_top
	import jfhs_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	jfhs_stream_if.sink   feed,
	jfhs_stream_if.source result
);

	typedef enum logic [3:0] {
		PH_SOI_HI,
		PH_SOI_LO,
		PH_MARK_HI,
		PH_MARK_LO,
		PH_LEN_HI,
		PH_LEN_LO,
		PH_SKIP,
		PH_FRAME,
		PH_DRAIN
	} phase_t;

	phase_t          phase_q, phase_n;
	logic [2:0]      field_count_q, field_count_n;
	logic [15:0]     marker_word_q, marker_word_n;
	logic [15:0]     segment_length_q, segment_length_n;
	logic [15:0]     skip_remaining_q, skip_remaining_n;
	logic [15:0]     height_hold_q, height_hold_n;
	logic [15:0]     width_hold_q, width_hold_n;
	logic [7:0]      precision_hold_q, precision_hold_n;
	logic            res_valid_q;
	result_payload_t res_payload_q;

	logic            accept;
	logic [7:0]      b;
	logic            last;
	logic            emit;
	status_t         emit_status;
	color_space_t    emit_cs;
	logic            emit_inv;
	logic [15:0]     word;
	logic [15:0]     skip_calc;
	logic            is_frame;
	result_payload_t res_n;

	assign feed.ready     = !res_valid_q || result.ready;
	assign accept         = feed.valid && feed.ready;
	assign b              = feed.payload.data_byte;
	assign last           = feed.payload.last_byte;
	assign result.valid   = res_valid_q;
	assign result.payload = res_payload_q;

	assign is_frame = (marker_word_q == MARKER_SOF0) || (marker_word_q == MARKER_SOF1) ||
		(marker_word_q == MARKER_SOF2) || (marker_word_q == MARKER_SOF9);

	always_comb begin
		phase_n          = phase_q;
		field_count_n    = field_count_q;
		marker_word_n    = marker_word_q;
		segment_length_n = segment_length_q;
		skip_remaining_n = skip_remaining_q;
		height_hold_n    = height_hold_q;
		width_hold_n     = width_hold_q;
		precision_hold_n = precision_hold_q;
		emit             = 1'b0;
		emit_status      = STATUS_OK;
		emit_cs          = COLOR_GRAY;
		emit_inv         = 1'b0;
		word             = {segment_length_q[15:8], b};
		skip_calc        = word - 16'd2;

		unique case (phase_q)
			PH_SOI_HI: begin
				marker_word_n = {8'h00, b};
				phase_n       = PH_SOI_LO;
			end
			PH_SOI_LO: begin
				marker_word_n = {marker_word_q[7:0], b};
				if ({marker_word_q[7:0], b} != MARKER_SOI) begin
					emit        = 1'b1;
					emit_status = STATUS_NO_SOI;
				end else begin
					phase_n = PH_MARK_HI;
				end
			end
			PH_MARK_HI: begin
				marker_word_n = {b, 8'h00};
				phase_n       = PH_MARK_LO;
			end
			PH_MARK_LO: begin
				marker_word_n = {marker_word_q[15:8], b};
				phase_n       = PH_LEN_HI;
			end
			PH_LEN_HI: begin
				segment_length_n = {b, 8'h00};
				phase_n          = PH_LEN_LO;
			end
			PH_LEN_LO: begin
				segment_length_n = word;
				if (is_frame) begin
					field_count_n = 3'd0;
					phase_n       = PH_FRAME;
				end else if (marker_word_q[15:8] != MARKER_PREFIX || word < 16'd2) begin
					emit        = 1'b1;
					emit_status = STATUS_LOST;
				end else begin
					skip_remaining_n = skip_calc;
					phase_n          = (skip_calc == 16'd0) ? PH_MARK_HI : PH_SKIP;
				end
			end
			PH_SKIP: begin
				skip_remaining_n = skip_remaining_q - 16'd1;
				if (skip_remaining_q == 16'd1) begin
					phase_n = PH_MARK_HI;
				end
			end
			PH_FRAME: begin
				field_count_n = field_count_q + 3'd1;
				unique case (field_count_q)
					3'd0: precision_hold_n = b;
					3'd1: height_hold_n    = {b, 8'h00};
					3'd2: height_hold_n    = {height_hold_q[15:8], b};
					3'd3: width_hold_n     = {b, 8'h00};
					3'd4: width_hold_n     = {width_hold_q[15:8], b};
					default: begin
						emit = 1'b1;
						priority if (b == COMPONENTS_GRAY) begin
							emit_cs = COLOR_GRAY;
						end else if (b == COMPONENTS_RGB) begin
							emit_cs = COLOR_RGB;
						end else if (b == COMPONENTS_CMYK) begin
							emit_cs  = COLOR_CMYK;
							emit_inv = 1'b1;
						end else begin
							emit_status = STATUS_BAD_COMP;
						end
					end
				endcase
			end
			default: begin
			end
		endcase

		if (!emit && last && phase_q != PH_DRAIN) begin
			emit        = 1'b1;
			emit_status = STATUS_TRUNC;
		end

		if (emit) begin
			phase_n = PH_DRAIN;
		end

		if (last) begin
			phase_n          = PH_SOI_HI;
			field_count_n    = 3'd0;
			marker_word_n    = 16'd0;
			segment_length_n = 16'd0;
			skip_remaining_n = 16'd0;
			height_hold_n    = 16'd0;
			width_hold_n     = 16'd0;
			precision_hold_n = 8'd0;
		end

		res_n.status = emit_status;
		if (emit_status == STATUS_OK) begin
			res_n.height        = height_hold_q;
			res_n.width         = width_hold_q;
			res_n.precision     = precision_hold_q;
			res_n.color_space   = emit_cs;
			res_n.invert_decode = emit_inv;
		end else begin
			res_n.height        = 16'd0;
			res_n.width         = 16'd0;
			res_n.precision     = 8'd0;
			res_n.color_space   = COLOR_GRAY;
			res_n.invert_decode = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q          <= PH_SOI_HI;
			field_count_q    <= 3'd0;
			marker_word_q    <= 16'd0;
			segment_length_q <= 16'd0;
			skip_remaining_q <= 16'd0;
			height_hold_q    <= 16'd0;
			width_hold_q     <= 16'd0;
			precision_hold_q <= 8'd0;
			res_valid_q      <= 1'b0;
		end else begin
			if (accept) begin
				phase_q          <= phase_n;
				field_count_q    <= field_count_n;
				marker_word_q    <= marker_word_n;
				segment_length_q <= segment_length_n;
				skip_remaining_q <= skip_remaining_n;
				height_hold_q    <= height_hold_n;
				width_hold_q     <= width_hold_n;
				precision_hold_q <= precision_hold_n;
			end
			if (accept && emit) begin
				res_valid_q <= 1'b1;
			end else if (result.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && emit) begin
			res_payload_q <= res_n;
		end
	end

endmodule

`default_nettype wire

// ===== sim/jfhs_header_checker.sv =====
// Watches both channels of the scanner, predicts each result and compares it.
module jfhs_header_checker
	import jfhs_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	input  logic            feed_valid,
	input  logic            feed_ready,
	input  feed_payload_t   feed_data,
	input  logic            result_valid,
	input  logic            result_ready,
	input  result_payload_t result_data,
	output int              fail_count,
	output int              pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef enum logic [3:0] {
		WAIT_SOI_HI,
		WAIT_SOI_LO,
		WAIT_MARK_HI,
		WAIT_MARK_LO,
		WAIT_LEN_HI,
		WAIT_LEN_LO,
		SKIP_PAYLOAD,
		READ_FRAME,
		DRAIN_FILE
	} scan_phase_t;

	scan_phase_t     phase;
	logic [2:0]      field_count;
	logic [15:0]     marker_word;
	logic [15:0]     segment_length;
	logic [15:0]     skip_remaining;
	logic [15:0]     height_hold;
	logic [15:0]     width_hold;
	logic [7:0]      precision_hold;
	result_payload_t expected_headers[$];
	int              result_index;

	task automatic clear_scan();
		phase = WAIT_SOI_HI;
		field_count = '0;
		marker_word = '0;
		segment_length = '0;
		skip_remaining = '0;
		height_hold = '0;
		width_hold = '0;
		precision_hold = '0;
	endtask

	task automatic flag_mismatch(input string what, input logic [15:0] got,
			input logic [15:0] want);
		$display("%0t: result %0d: %s is %0h, expected %0h", $realtime, result_index,
			what, got, want);
		fail_count++;
	endtask

	task automatic post_header(input status_t st, input color_space_t cs, input logic inv,
			input logic fin);
		result_payload_t hdr;
		hdr = '0;
		hdr.status = st;
		if (st == STATUS_OK) begin
			hdr.height = height_hold;
			hdr.width = width_hold;
			hdr.precision = precision_hold;
			hdr.color_space = cs;
			hdr.invert_decode = inv;
		end
		expected_headers.push_back(hdr);
		if (fin) begin
			clear_scan();
		end else begin
			phase = DRAIN_FILE;
		end
	endtask

	task automatic scan_byte(input logic [7:0] b, input logic fin);
		logic emitted;
		logic is_frame;
		emitted = 1'b0;
		case (phase)
			WAIT_SOI_HI: begin
				marker_word = {8'h00, b};
				phase = WAIT_SOI_LO;
			end
			WAIT_SOI_LO: begin
				marker_word = {marker_word[7:0], b};
				if (marker_word != MARKER_SOI) begin
					post_header(STATUS_NO_SOI, COLOR_GRAY, 1'b0, fin);
					emitted = 1'b1;
				end else begin
					phase = WAIT_MARK_HI;
				end
			end
			WAIT_MARK_HI: begin
				marker_word = {b, 8'h00};
				phase = WAIT_MARK_LO;
			end
			WAIT_MARK_LO: begin
				marker_word = {marker_word[15:8], b};
				phase = WAIT_LEN_HI;
			end
			WAIT_LEN_HI: begin
				segment_length = {b, 8'h00};
				phase = WAIT_LEN_LO;
			end
			WAIT_LEN_LO: begin
				segment_length = {segment_length[15:8], b};
				is_frame = marker_word == MARKER_SOF0 || marker_word == MARKER_SOF1 ||
					marker_word == MARKER_SOF2 || marker_word == MARKER_SOF9;
				if (is_frame) begin
					field_count = '0;
					phase = READ_FRAME;
				end else if (marker_word[15:8] != MARKER_PREFIX || segment_length < 16'd2) begin
					post_header(STATUS_LOST, COLOR_GRAY, 1'b0, fin);
					emitted = 1'b1;
				end else begin
					skip_remaining = segment_length - 16'd2;
					phase = (skip_remaining == '0) ? WAIT_MARK_HI : SKIP_PAYLOAD;
				end
			end
			SKIP_PAYLOAD: begin
				skip_remaining = skip_remaining - 16'd1;
				if (skip_remaining == '0) begin
					phase = WAIT_MARK_HI;
				end
			end
			READ_FRAME: begin
				case (field_count)
					3'd0: precision_hold = b;
					3'd1: height_hold = {b, 8'h00};
					3'd2: height_hold = {height_hold[15:8], b};
					3'd3: width_hold = {b, 8'h00};
					3'd4: width_hold = {width_hold[15:8], b};
					default: begin
						emitted = 1'b1;
						case (b)
							COMPONENTS_GRAY: post_header(STATUS_OK, COLOR_GRAY, 1'b0, fin);
							COMPONENTS_RGB:  post_header(STATUS_OK, COLOR_RGB, 1'b0, fin);
							COMPONENTS_CMYK: post_header(STATUS_OK, COLOR_CMYK, 1'b1, fin);
							default:         post_header(STATUS_BAD_COMP, COLOR_GRAY, 1'b0, fin);
						endcase
					end
				endcase
				if (!emitted) begin
					field_count = field_count + 3'd1;
				end
			end
			default: begin
				emitted = 1'b1;
				if (fin) begin
					clear_scan();
				end
			end
		endcase
		if (!emitted && fin) begin
			post_header(STATUS_TRUNC, COLOR_GRAY, 1'b0, 1'b1);
		end
	endtask

	task automatic compare_header(input result_payload_t got);
		result_payload_t want;
		if (expected_headers.size() == 0) begin
			flag_mismatch("unexpected transaction, status", 16'(got.status), '0);
		end else begin
			want = expected_headers.pop_front();
			if (got.status !== want.status) begin
				flag_mismatch("status", 16'(got.status), 16'(want.status));
			end
			if (got.height !== want.height) begin
				flag_mismatch("height", got.height, want.height);
			end
			if (got.width !== want.width) begin
				flag_mismatch("width", got.width, want.width);
			end
			if (got.precision !== want.precision) begin
				flag_mismatch("precision", 16'(got.precision), 16'(want.precision));
			end
			if (got.color_space !== want.color_space) begin
				flag_mismatch("color_space", 16'(got.color_space), 16'(want.color_space));
			end
			if (got.invert_decode !== want.invert_decode) begin
				flag_mismatch("invert_decode", 16'(got.invert_decode),
					16'(want.invert_decode));
			end
		end
		result_index++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_scan();
			expected_headers.delete();
			fail_count = 0;
			result_index = 0;
			pending <= 0;
		end else begin
			if (feed_valid && feed_ready) begin
				scan_byte(feed_data.data_byte, feed_data.last_byte);
			end
			if (result_valid && result_ready) begin
				compare_header(result_data);
			end
			pending <= expected_headers.size();
		end
	end
endmodule

// ===== sim/tb_jpeg_frame_header_scanner_top.sv =====
// Testbench top for the JPEG frame header scanner: clock, reset, byte files and verdict.
module tb_jpeg_frame_header_scanner_top;
	timeunit 1ns;
	timeprecision 1ps;
	import jfhs_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int RANDOM_BYTES = 1350;
	localparam int MIN_FILES = 40;

	logic       clk = 1'b0;
	logic       arst_n;
	int         feed_gap_pct = 17;
	int         sink_stall_pct = 17;
	int         fail_count;
	int         open_results;
	int         cycle_count;
	int         sent_bytes;
	int         file_index;
	logic [7:0] file_bytes[$];

	jfhs_stream_if #(.payload_t(feed_payload_t)) feed ();
	jfhs_stream_if #(.payload_t(result_payload_t)) result ();

	jpeg_frame_header_scanner_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.feed   (feed),
		.result (result)
	);

	jfhs_header_checker checker_0 (
		.clk          (clk),
		.arst_n       (arst_n),
		.feed_valid   (feed.valid),
		.feed_ready   (feed.ready),
		.feed_data    (feed.payload),
		.result_valid (result.valid),
		.result_ready (result.ready),
		.result_data  (result.payload),
		.fail_count   (fail_count),
		.pending      (open_results)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		result.ready = 1'b0;
		forever begin
			@(posedge clk);
			result.ready <= ($urandom_range(99) >= sink_stall_pct);
		end
	end

	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("CHECK FAILED");
		$finish;
	end

	task automatic send_byte(input logic [7:0] b, input logic fin);
		feed_payload_t item;
		item.data_byte = b;
		item.last_byte = fin;
		while ($urandom_range(99) < feed_gap_pct) begin
			feed.valid <= 1'b0;
			@(posedge clk);
		end
		feed.valid <= 1'b1;
		feed.payload <= item;
		@(posedge clk);
		while (!feed.ready) begin
			@(posedge clk);
		end
		sent_bytes++;
	endtask

	task automatic send_file();
		for (int i = 0; i < file_bytes.size(); i++) begin
			send_byte(file_bytes[i], i == file_bytes.size() - 1);
		end
	endtask

	task automatic wait_drained();
		feed.valid <= 1'b0;
		@(posedge clk);
		while (open_results != 0) begin
			@(posedge clk);
		end
	endtask

	function automatic logic [15:0] pick_dimension();
		case ($urandom_range(5))
			0: return 16'h0000;
			1: return 16'hFFFF;
			default: return 16'($urandom_range(65535));
		endcase
	endfunction

	task automatic build_random_file();
		int         kind;
		int         nseg;
		int         pay;
		int         cut;
		logic [15:0] seg_len;
		logic [15:0] h;
		logic [15:0] w;
		logic [7:0] comp;
		kind = $urandom_range(99);
		file_bytes.delete();
		if (kind < 12) begin
			repeat ($urandom_range(1, 8)) file_bytes.push_back(8'($urandom_range(255)));
		end else begin
			file_bytes.push_back(8'hFF);
			file_bytes.push_back(($urandom_range(99) < 4) ? 8'($urandom_range(255)) : 8'hD8);
			nseg = (kind < 28) ? $urandom_range(1, 2) : $urandom_range(0, 2);
			for (int s = 0; s < nseg; s++) begin
				if (kind < 28 && s == 0 && kind[0]) begin
					file_bytes.push_back(8'($urandom_range(254)));
				end else begin
					file_bytes.push_back(8'hFF);
				end
				file_bytes.push_back(8'($urandom_range(255)));
				pay = ($urandom_range(49) == 0) ? $urandom_range(250, 300) : $urandom_range(0, 4);
				seg_len = 16'(pay + 2);
				if (kind < 28 && s == 0 && !kind[0]) begin
					seg_len = 16'($urandom_range(1));
				end
				file_bytes.push_back(seg_len[15:8]);
				file_bytes.push_back(seg_len[7:0]);
				repeat (pay) file_bytes.push_back(8'($urandom_range(255)));
			end
			file_bytes.push_back(8'hFF);
			case ($urandom_range(3))
				0: file_bytes.push_back(MARKER_SOF0[7:0]);
				1: file_bytes.push_back(MARKER_SOF1[7:0]);
				2: file_bytes.push_back(MARKER_SOF2[7:0]);
				default: file_bytes.push_back(MARKER_SOF9[7:0]);
			endcase
			seg_len = 16'($urandom_range(65535));
			h = pick_dimension();
			w = pick_dimension();
			case ($urandom_range(4))
				0: comp = COMPONENTS_GRAY;
				1: comp = COMPONENTS_RGB;
				2: comp = COMPONENTS_CMYK;
				default: comp = 8'($urandom_range(255));
			endcase
			file_bytes.push_back(seg_len[15:8]);
			file_bytes.push_back(seg_len[7:0]);
			file_bytes.push_back(8'($urandom_range(255)));
			file_bytes.push_back(h[15:8]);
			file_bytes.push_back(h[7:0]);
			file_bytes.push_back(w[15:8]);
			file_bytes.push_back(w[7:0]);
			file_bytes.push_back(comp);
			repeat ($urandom_range(0, 3)) file_bytes.push_back(8'($urandom_range(255)));
			if ($urandom_range(99) < 15) begin
				cut = $urandom_range(1, file_bytes.size());
				while (file_bytes.size() > cut) void'(file_bytes.pop_back());
			end
		end
	endtask

	initial begin
		feed.valid = 1'b0;
		feed.payload = '0;
		arst_n = 1'b0;
		sent_bytes = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		file_bytes = '{8'hFF};
		send_file();
		file_bytes = '{8'hFF, 8'hD9};
		send_file();
		file_bytes = '{8'h00, 8'hD8, 8'hA5};
		send_file();
		file_bytes = '{8'hFF, 8'hD8, 8'hFF, 8'hC0, 8'h00, 8'h11, 8'hFF, 8'hFF, 8'hFF, 8'h00,
			8'h00, 8'h04};
		send_file();
		file_bytes = '{8'hFF, 8'hD8, 8'hFF, 8'hE0, 8'h00, 8'h04, 8'h12, 8'h34, 8'hFF, 8'hC1,
			8'h00, 8'h00, 8'h08, 8'h00, 8'h01, 8'h01, 8'h00, 8'h01, 8'hEE};
		send_file();
		file_bytes = '{8'hFF, 8'hD8, 8'hFF, 8'hDB, 8'h00, 8'h02, 8'hFF, 8'hC2, 8'h00, 8'h11,
			8'h0C, 8'h12, 8'h34, 8'h56, 8'h78, 8'h03, 8'h00};
		send_file();
		file_bytes = '{8'hFF, 8'hD8, 8'h7F, 8'hC9, 8'h00, 8'h08};
		send_file();
		file_bytes = '{8'hFF, 8'hD8, 8'hFF, 8'hFE, 8'h00, 8'h01, 8'h55};
		send_file();
		file_bytes = '{8'hFF, 8'hD8, 8'hFF, 8'hC9, 8'h00, 8'h0B, 8'h08, 8'h00, 8'h10, 8'h00,
			8'h20, 8'h02, 8'h77};
		send_file();
		file_bytes = '{8'hFF, 8'hD8, 8'hFF, 8'hE1, 8'h00, 8'h05, 8'h01, 8'h02};
		send_file();
		wait_drained();

		sent_bytes = 0;
		file_index = 0;
		while (sent_bytes < RANDOM_BYTES || file_index < MIN_FILES) begin
			if (file_index == 10) begin
				feed_gap_pct = 0;
				sink_stall_pct = 0;
			end else if (file_index == 25) begin
				feed_gap_pct = 17;
				sink_stall_pct = 17;
			end else if (file_index == 30) begin
				wait_drained();
			end
			build_random_file();
			send_file();
			file_index++;
		end

		wait_drained();
		repeat (10) @(posedge clk);
		if (fail_count == 0 && open_results == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end
endmodule

// ===== files.f =====
rtl/jfhs_pkg.sv
rtl/jfhs_stream_if.sv
rtl/jpeg_frame_header_scanner_top.sv
sim/jfhs_header_checker.sv
sim/tb_jpeg_frame_header_scanner_top.sv
